// ----- sv/bilinear_image_scaler_core_assert.svh -----
// Assertion macros shared by the scaler modules.
// Depends on nothing; included inside module bodies.
`ifndef BILINEAR_IMAGE_SCALER_CORE_ASSERT_SVH
`define BILINEAR_IMAGE_SCALER_CORE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define BIS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define BIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- sv/bis_pkg.sv -----
`default_nettype none
// Shared types and constants for the bilinear image scaler.
// Depends on nothing.
package bis_pkg;
	localparam int REG_ROWS = 0;
	localparam int REG_COLS = 1;
	localparam int REG_RSTEP = 2;
	localparam int REG_CSTEP = 3;
	localparam int REG_MODE = 4;
	localparam int CFG_W = 26;
	localparam int CFG_IDX_W = 3;
	localparam int COORD_W = 10;
	localparam int PIX_W = 8;

	// frame and coordinate geometry; port widths are sized for these
	localparam int MAX_SRC_DIM = 512;
	localparam int MAX_DST_DIM = 1024;
	localparam int FRAC_BITS = 16;

	// controller state, one-hot
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_ADR  = 7'b0000100,
		ST_RD   = 7'b0001000,
		ST_W1   = 7'b0010000,
		ST_W2   = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // capture request
		logic write_px;  // store source pixel
		logic mul;       // form source positions
		logic adr;       // clamp and latch addresses
		logic rd;        // issue neighbor read (index in rd_sel)
		logic [1:0] rd_sel;
		logic acc;       // accumulate weighted term
		logic acc_clr;
		logic done;      // present result
	} dp_cmd_t;
endpackage
`default_nettype wire

// ----- sv/bis_ctrl.sv -----
`default_nettype none
// Scaler controller: sequences one request through the datapath.
// Depends on bis_pkg and the assertion macro header.
module bis_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic func,
	input  wire logic in_range,   // compute destination inside the frame
	output logic busy,
	output bis_pkg::dp_cmd_t cmd
);
	import bis_pkg::*;
	`include "bilinear_image_scaler_core_assert.svh"

	state_t state_q;
	logic [1:0] nb_q;   // neighbor counter: four reads, one each cycle
	logic go;

	assign go = start && !busy;
	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nb_q <= 2'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (go && func && in_range) state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_ADR;
				ST_ADR: begin
					nb_q <= 2'd0;
					state_q <= ST_RD;
				end
				ST_RD: begin
					nb_q <= nb_q + 2'd1;
					if (nb_q == 2'd3) state_q <= ST_W1;
				end
				ST_W1: state_q <= ST_W2;
				ST_W2: state_q <= ST_OUT;
				ST_OUT: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// read pipeline: read issued in RD, data next cycle, then the registered product
	logic rd_s1, rd_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
			rd_s2 <= 1'b0;
		end else begin
			rd_s1 <= (state_q == ST_RD);
			rd_s2 <= rd_s1;
		end
	end

	always_comb begin
		cmd = '0;
		cmd.load = go;
		cmd.write_px = go && !func;
		cmd.mul = (state_q == ST_MUL);
		cmd.adr = (state_q == ST_ADR);
		cmd.acc_clr = (state_q == ST_ADR);
		cmd.rd = (state_q == ST_RD);
		cmd.rd_sel = nb_q;
		cmd.acc = rd_s2;
		cmd.done = (state_q == ST_OUT);
	end

	`BIS_ASSERT_NEXT(a_out_idle, clk, arst_n, state_q == ST_OUT, state_q == ST_IDLE)
	`BIS_ASSERT_IMPL(a_acc_only_late, clk, arst_n, cmd.acc,
		state_q == ST_RD || state_q == ST_W1 || state_q == ST_W2)
	`BIS_ASSERT_NEXT(a_start_busy, clk, arst_n, go && func && in_range, busy)
endmodule
`default_nettype wire

// ----- sv/bis_datapath.sv -----
`default_nettype none
// Scaler datapath: frame store, coordinate mapping, weighted accumulate.
// Depends on bis_pkg and the assertion macro header.
module bis_datapath (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire bis_pkg::dp_cmd_t cmd,
	input  wire logic [bis_pkg::COORD_W-1:0] row,
	input  wire logic [bis_pkg::COORD_W-1:0] col,
	input  wire logic [bis_pkg::PIX_W-1:0] pixel_in,
	input  wire logic [bis_pkg::COORD_W-1:0] source_rows,
	input  wire logic [bis_pkg::COORD_W-1:0] source_cols,
	input  wire logic [bis_pkg::CFG_W-1:0] row_step,
	input  wire logic [bis_pkg::CFG_W-1:0] col_step,
	input  wire logic interp_mode,
	output logic in_range,
	output logic done,
	output logic [bis_pkg::PIX_W-1:0] pixel_out,
	output logic [bis_pkg::COORD_W-1:0] out_row,
	output logic [bis_pkg::COORD_W-1:0] out_col
);
	import bis_pkg::*;
	`include "bilinear_image_scaler_core_assert.svh"

	localparam int SW = $clog2(MAX_SRC_DIM);
	localparam int DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;
	localparam int PW = COORD_W + CFG_W;       // position width
	localparam int IW = PW - FRAC_BITS;        // integer part width
	localparam int WW = FRAC_BITS + 1;         // weight width, holds 1.0
	localparam int AW = 2 * WW + PIX_W;        // accumulator width

	logic [PIX_W-1:0] mem [DEPTH];

	assign in_range = ({1'b0, row} < (COORD_W+1)'(MAX_DST_DIM))
		&& ({1'b0, col} < (COORD_W+1)'(MAX_DST_DIM));

	logic wr_ok;
	assign wr_ok = ({1'b0, row} < (COORD_W+1)'(MAX_SRC_DIM))
		&& ({1'b0, col} < (COORD_W+1)'(MAX_SRC_DIM));

	// request capture
	logic [COORD_W-1:0] row_q, col_q;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			row_q <= row;
			col_q <= col;
		end
	end

	// source positions
	logic [PW-1:0] pr_q, pc_q;
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			pr_q <= PW'(row_q) * PW'(row_step);
			pc_q <= PW'(col_q) * PW'(col_step);
		end
	end

	// effective last index: 0 treated as 1, large clamped
	function automatic logic [IW-1:0] last_idx(input logic [COORD_W-1:0] d);
		logic [IW-1:0] v;
		begin
			v = (d == '0) ? IW'(1) : IW'(d);
			if (v > IW'(MAX_SRC_DIM)) v = IW'(MAX_SRC_DIM);
			return v - IW'(1);
		end
	endfunction

	logic [IW-1:0] lr, lc, ir, ic, r0, c0, r1, c1, rn, cn;
	logic [PW:0] prh, pch;
	always_comb begin
		lr = last_idx(source_rows);
		lc = last_idx(source_cols);
		prh = {1'b0, pr_q} + (PW+1)'(1 << (FRAC_BITS-1));
		pch = {1'b0, pc_q} + (PW+1)'(1 << (FRAC_BITS-1));
		ir = pr_q[PW-1:FRAC_BITS];
		ic = pc_q[PW-1:FRAC_BITS];
		r0 = (ir > lr) ? lr : ir;
		c0 = (ic > lc) ? lc : ic;
		r1 = (r0 == lr) ? lr : r0 + IW'(1);
		c1 = (c0 == lc) ? lc : c0 + IW'(1);
		rn = (prh[PW:FRAC_BITS] > (IW+1)'(lr)) ? lr : IW'(prh[PW:FRAC_BITS]);
		cn = (pch[PW:FRAC_BITS] > (IW+1)'(lc)) ? lc : IW'(pch[PW:FRAC_BITS]);
	end

	logic [SW-1:0] r0_q, c0_q, r1_q, c1_q;
	logic [WW-1:0] fr_q, fc_q;
	always_ff @(posedge clk) begin
		if (cmd.adr) begin
			if (interp_mode) begin
				r0_q <= SW'(r0);
				c0_q <= SW'(c0);
				r1_q <= SW'(r1);
				c1_q <= SW'(c1);
				fr_q <= WW'(pr_q[FRAC_BITS-1:0]);
				fc_q <= WW'(pc_q[FRAC_BITS-1:0]);
			end else begin
				// nearest: all four taps on one pixel, full weight on the first
				r0_q <= SW'(rn);
				c0_q <= SW'(cn);
				r1_q <= SW'(rn);
				c1_q <= SW'(cn);
				fr_q <= '0;
				fc_q <= '0;
			end
		end
	end

	// one memory port, one neighbor a cycle
	logic [SW-1:0] ra, ca;
	logic [WW-1:0] wa, wb;
	logic [WW-1:0] one_w;
	assign one_w = WW'(1) << FRAC_BITS;
	always_comb begin
		case (cmd.rd_sel)
			2'd0: begin ra = r0_q; ca = c0_q; wa = one_w - fr_q; wb = one_w - fc_q; end
			2'd1: begin ra = r0_q; ca = c1_q; wa = one_w - fr_q; wb = fc_q; end
			2'd2: begin ra = r1_q; ca = c0_q; wa = fr_q; wb = one_w - fc_q; end
			2'd3: begin ra = r1_q; ca = c1_q; wa = fr_q; wb = fc_q; end
			default: begin ra = r0_q; ca = c0_q; wa = '0; wb = '0; end
		endcase
	end

	logic [PIX_W-1:0] rdata_s1;
	logic [2*WW-1:0] w_s1;
	logic [AW-1:0] prod_s2, acc_q;
	always_ff @(posedge clk) begin
		if (cmd.write_px && wr_ok)
			mem[{SW'(row), SW'(col)}] <= pixel_in;
		if (cmd.rd) begin
			rdata_s1 <= mem[{ra, ca}];
			w_s1 <= (2*WW)'(wa) * (2*WW)'(wb);
		end
		prod_s2 <= AW'(w_s1) * AW'(rdata_s1);
		if (cmd.acc_clr)
			acc_q <= '0;
		else if (cmd.acc)
			acc_q <= acc_q + prod_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= cmd.done;
	end
	always_ff @(posedge clk) begin
		if (cmd.done) begin
			pixel_out <= acc_q[2*FRAC_BITS +: PIX_W];
			out_row <= row_q;
			out_col <= col_q;
		end
	end

	`BIS_ASSERT_IMPL(a_no_rd_on_load, clk, arst_n, cmd.rd, !cmd.load)
	`BIS_ASSERT_IMPL(a_no_acc_clr, clk, arst_n, cmd.acc, !cmd.acc_clr)
	`BIS_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
endmodule
`default_nettype wire

// ----- sv/bilinear_image_scaler_core.sv -----
`default_nettype none
// Top level of the grayscale image scaler: controller plus datapath.
// Depends on bis_pkg, bis_ctrl and bis_datapath.
//
// Usage: raise start with func/row/col/pixel_in; the request is taken at
// an edge where start is high and busy is low. A write (func 0) stores
// pixel_in into the frame store in that cycle if row and col are below
// MAX_SRC_DIM, and leaves busy low, so idle writes go one per cycle. A
// compute (func 1) maps the destination pixel back to the source and
// returns pixel_out/out_row/out_col with strobe high for one cycle. It
// passes the multiply and address stages, then the single frame-store
// read port fetches the four neighbors one per cycle, then the weight
// pipeline stages; busy stays high until the strobe cycle, so no new
// request is taken meanwhile. A compute whose destination lies outside
// MAX_DST_DIM gives no strobe. Configuration: cfg_we/cfg_idx/cfg_data
// write a register at once; the user must write only while idle, the
// block does not enforce it. Reset clears the controller and reloads the
// register defaults; the frame store is undefined until written. The
// receiver cannot stall: each result is valid only in its strobe cycle.
module bilinear_image_scaler_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire logic func,
	input  wire logic [bis_pkg::COORD_W-1:0] row,
	input  wire logic [bis_pkg::COORD_W-1:0] col,
	input  wire logic [bis_pkg::PIX_W-1:0] pixel_in,
	output logic strobe,
	output logic [bis_pkg::PIX_W-1:0] pixel_out,
	output logic [bis_pkg::COORD_W-1:0] out_row,
	output logic [bis_pkg::COORD_W-1:0] out_col,
	input  wire logic cfg_we,
	input  wire logic [bis_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [bis_pkg::CFG_W-1:0] cfg_data
);
	import bis_pkg::*;

	logic [COORD_W-1:0] source_rows_q, source_cols_q;
	logic [CFG_W-1:0] row_step_q, col_step_q;
	logic interp_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_rows_q <= COORD_W'(512);
			source_cols_q <= COORD_W'(512);
			row_step_q <= CFG_W'(43691);
			col_step_q <= CFG_W'(43691);
			interp_mode_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_IDX_W'(REG_ROWS): source_rows_q <= cfg_data[COORD_W-1:0];
				CFG_IDX_W'(REG_COLS): source_cols_q <= cfg_data[COORD_W-1:0];
				CFG_IDX_W'(REG_RSTEP): row_step_q <= cfg_data;
				CFG_IDX_W'(REG_CSTEP): col_step_q <= cfg_data;
				CFG_IDX_W'(REG_MODE): interp_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	dp_cmd_t cmd;
	logic in_range;

	bis_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .func(func),
		.in_range(in_range), .busy(busy), .cmd(cmd)
	);

	bis_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .row(row), .col(col),
		.pixel_in(pixel_in), .source_rows(source_rows_q),
		.source_cols(source_cols_q), .row_step(row_step_q),
		.col_step(col_step_q), .interp_mode(interp_mode_q),
		.in_range(in_range), .done(strobe), .pixel_out(pixel_out),
		.out_row(out_row), .out_col(out_col)
	);
endmodule
`default_nettype wire
